### rtl/assert_macros.svh
// Assertion macros shared by the framebuffer plot and span engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition never holds at a clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### rtl/fbps_pkg.sv
// Types and constants of the framebuffer plot and span engine.
package fbps_pkg;

  typedef enum logic [1:0] {
    OP_PLOT  = 2'd0,
    OP_SPAN  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_GET   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_PLOT,
    ST_SPAN,
    ST_CLEAR,
    ST_GET_IDX,
    ST_GET_DATA
  } state_e;

  localparam int unsigned DimW    = 10;
  localparam int unsigned CoordW  = 16;
  localparam int unsigned ColorW  = 32;
  localparam int unsigned RowW    = 18;
  localparam int unsigned ProdW   = 29;
  localparam int unsigned IdxW    = 30;
  localparam int unsigned AreaW   = 20;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned InDataW = 80;

  localparam logic [CfgIdxW-1:0] CFG_FRAME_WIDTH    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FRAME_HEIGHT   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_FALLBACK_COLOR = 2'd2;

  localparam logic [DimW-1:0]   FRAME_DIM_RST      = 10'd512;
  localparam logic [ColorW-1:0] FALLBACK_COLOR_RST = 32'hFFFF_FFFF;

endpackage

### rtl/fbps_ram.sv
// Generic single-port synchronous RAM with registered read.
module fbps_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/framebuffer_plot_span_engine_core.sv
// Framebuffer plot, span fill, clear and pixel read engine: top level.
//
// The frame lives in one single-port memory of MAX_WIDTH*MAX_HEIGHT words of
// 32-bit BGRA, one access per cycle, rows stored bottom-up. One item is worked
// on at a time. After the input transfer the CALC state forms the row base
// (one multiply); then plot makes one write, span fill one write per pixel of
// the clipped run, clear one write per pixel of the active frame (width*height),
// and get returns the fallback color when the index lies outside the frame or
// reads the memory otherwise, both after any wait for the output slot. A plot
// or span fill that writes nothing returns to idle straight from CALC.
// The memory is not initialized: issue a clear before any get.
// Only get produces an output transfer; the output register holds it while
// the next item is taken.
`include "assert_macros.svh"

module framebuffer_plot_span_engine_core #(
  parameter int unsigned MAX_WIDTH  = 512,
  parameter int unsigned MAX_HEIGHT = 512
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fbps_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [fbps_pkg::ColorW-1:0]       cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // pos_x[15:0], pos_y[31:16], end_x[47:32], paint_color[79:48]
  input  logic [fbps_pkg::InDataW-1:0]      s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // read_color[31:0]
  output logic [fbps_pkg::ColorW-1:0]       m_axis_tdata,
  // outside_frame[0]
  output logic                              m_axis_tuser
);

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned ColW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WCap  = (MAX_WIDTH < 1023) ? MAX_WIDTH : 1023;
  localparam int unsigned HCap  = (MAX_HEIGHT < 1023) ? MAX_HEIGHT : 1023;

  localparam int unsigned DimW   = fbps_pkg::DimW;
  localparam int unsigned CoordW = fbps_pkg::CoordW;
  localparam int unsigned ColorW = fbps_pkg::ColorW;
  localparam int unsigned RowW   = fbps_pkg::RowW;
  localparam int unsigned ProdW  = fbps_pkg::ProdW;
  localparam int unsigned IdxW   = fbps_pkg::IdxW;
  localparam int unsigned AreaW  = fbps_pkg::AreaW;

  fbps_pkg::state_e state_q, state_d;

  logic [DimW-1:0]   fw_q, fh_q;
  logic [ColorW-1:0] fallback_q;
  logic [DimW-1:0]   w_act, h_act, w_m1;
  logic [AreaW-1:0]  area_q, area_d;

  fbps_pkg::op_e            op_q;
  logic signed [CoordW-1:0] x_q, y_q, last_q;
  logic [ColorW-1:0]        color_q;
  logic signed [CoordW-1:0] in_pos_x, in_pos_y, in_end_x;

  logic signed [RowW-1:0]   row_diff;
  logic signed [ProdW-1:0]  row_base_q, row_base_d;
  logic signed [IdxW-1:0]   idx_pt, idx_span;
  logic                     x_in, y_in, span_ok, get_out;
  logic signed [CoordW-1:0] start_s, end_s;

  logic [ColW-1:0]  col_q, col_d, span_end_q, span_end_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic             clr_last, span_last;

  logic              out_valid_q, out_valid_d, outside_q, outside_d, out_load, out_free;
  logic [ColorW-1:0] read_color_q, read_color_d;

  logic              ram_we, ram_re;
  logic [AddrW-1:0]  ram_addr;
  logic [ColorW-1:0] ram_rdata;

  // Configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q       <= fbps_pkg::FRAME_DIM_RST;
      fh_q       <= fbps_pkg::FRAME_DIM_RST;
      fallback_q <= fbps_pkg::FALLBACK_COLOR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fbps_pkg::CFG_FRAME_WIDTH:    fw_q       <= cfg_data_i[DimW-1:0];
        fbps_pkg::CFG_FRAME_HEIGHT:   fh_q       <= cfg_data_i[DimW-1:0];
        fbps_pkg::CFG_FALLBACK_COLOR: fallback_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign w_act  = (fw_q == '0) ? DimW'(1) : ((fw_q > DimW'(WCap)) ? DimW'(WCap) : fw_q);
  assign h_act  = (fh_q == '0) ? DimW'(1) : ((fh_q > DimW'(HCap)) ? DimW'(HCap) : fh_q);
  assign w_m1   = w_act - DimW'(1);
  assign area_d = {{(AreaW-DimW){1'b0}}, w_act} * {{(AreaW-DimW){1'b0}}, h_act};

  always_ff @(posedge clk_i) begin
    area_q <= area_d;
  end

  // Input capture
  assign in_pos_x = s_axis_tdata[15:0];
  assign in_pos_y = s_axis_tdata[31:16];
  assign in_end_x = s_axis_tdata[47:32];

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q    <= fbps_pkg::op_e'(s_axis_tuser);
      x_q     <= in_pos_x;
      y_q     <= in_pos_y;
      last_q  <= in_end_x;
      color_q <= s_axis_tdata[79:48];
    end
  end

  // Row base and clipping
  assign row_diff = $signed({{(RowW-DimW){1'b0}}, h_act}) - $signed(RowW'(1))
                    - RowW'(y_q);
  assign x_in     = !x_q[CoordW-1] && (x_q < $signed({{(CoordW-DimW){1'b0}}, w_act}));
  assign y_in     = !y_q[CoordW-1] && (y_q < $signed({{(CoordW-DimW){1'b0}}, h_act}));
  assign start_s  = x_q[CoordW-1] ? '0 : x_q;
  assign end_s    = (last_q > $signed({{(CoordW-DimW){1'b0}}, w_m1}))
                    ? $signed({{(CoordW-DimW){1'b0}}, w_m1}) : last_q;
  assign span_ok  = y_in && !(x_q > last_q) && (start_s <= end_s);

  assign idx_pt   = IdxW'(row_base_q) + IdxW'(x_q);
  assign idx_span = IdxW'(row_base_q) + $signed({{(IdxW-ColW){1'b0}}, col_q});
  assign get_out  = idx_pt[IdxW-1] ||
                    (idx_pt >= $signed({{(IdxW-AreaW){1'b0}}, area_q}));

  assign span_last = (col_q == span_end_q);
  assign clr_last  = ((32'(clr_q) + 32'd1) == 32'(area_q));
  assign out_free  = !out_valid_q || m_axis_tready;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fbps_pkg::ST_IDLE: begin
        if (s_axis_tvalid) state_d = fbps_pkg::ST_CALC;
      end
      fbps_pkg::ST_CALC: begin
        unique case (op_q)
          fbps_pkg::OP_PLOT:  state_d = (x_in && y_in) ? fbps_pkg::ST_PLOT : fbps_pkg::ST_IDLE;
          fbps_pkg::OP_SPAN:  state_d = span_ok ? fbps_pkg::ST_SPAN : fbps_pkg::ST_IDLE;
          fbps_pkg::OP_CLEAR: state_d = fbps_pkg::ST_CLEAR;
          fbps_pkg::OP_GET:   state_d = fbps_pkg::ST_GET_IDX;
        endcase
      end
      fbps_pkg::ST_PLOT: state_d = fbps_pkg::ST_IDLE;
      fbps_pkg::ST_SPAN: begin
        if (span_last) state_d = fbps_pkg::ST_IDLE;
      end
      fbps_pkg::ST_CLEAR: begin
        if (clr_last) state_d = fbps_pkg::ST_IDLE;
      end
      fbps_pkg::ST_GET_IDX: begin
        if (out_free) state_d = get_out ? fbps_pkg::ST_IDLE : fbps_pkg::ST_GET_DATA;
      end
      fbps_pkg::ST_GET_DATA: state_d = fbps_pkg::ST_IDLE;
      default: state_d = fbps_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_addr      = idx_pt[AddrW-1:0];
    row_base_d    = row_base_q;
    col_d         = col_q;
    span_end_d    = span_end_q;
    clr_d         = clr_q;
    out_load      = 1'b0;
    read_color_d  = read_color_q;
    outside_d     = outside_q;
    unique case (state_q)
      fbps_pkg::ST_IDLE: s_axis_tready = 1'b1;
      fbps_pkg::ST_CALC: begin
        row_base_d = ProdW'(row_diff) * ProdW'($signed({1'b0, w_act}));
        col_d      = start_s[ColW-1:0];
        span_end_d = end_s[ColW-1:0];
        clr_d      = '0;
      end
      fbps_pkg::ST_PLOT: ram_we = 1'b1;
      fbps_pkg::ST_SPAN: begin
        ram_we   = 1'b1;
        ram_addr = idx_span[AddrW-1:0];
        col_d    = col_q + ColW'(1);
      end
      fbps_pkg::ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_q;
        clr_d    = clr_q + AddrW'(1);
      end
      fbps_pkg::ST_GET_IDX: begin
        if (out_free) begin
          if (get_out) begin
            out_load     = 1'b1;
            read_color_d = fallback_q;
            outside_d    = 1'b1;
          end else begin
            ram_re = 1'b1;
          end
        end
      end
      fbps_pkg::ST_GET_DATA: begin
        out_load     = 1'b1;
        read_color_d = ram_rdata;
        outside_d    = 1'b0;
      end
      default: ;
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fbps_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_base_q   <= row_base_d;
    col_q        <= col_d;
    span_end_q   <= span_end_d;
    clr_q        <= clr_d;
    read_color_q <= read_color_d;
    outside_q    <= outside_d;
  end

  fbps_ram #(
    .WIDTH (ColorW),
    .DEPTH (Depth)
  ) u_pixel_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (color_q),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = read_color_q;
  assign m_axis_tuser  = outside_q;

  `ASSERT_NEVER(a_ram_rw_same_cycle, ram_we && ram_re, "pixel RAM read and write collide")
  `ASSERT_RST(a_load_into_free, out_load |-> (!out_valid_q || m_axis_tready), "output slot overwritten")
  `ASSERT_RST(a_span_in_run, (state_q == fbps_pkg::ST_SPAN) |-> (col_q <= span_end_q),
              "span column past end of run")
  `ASSERT_RST(a_clear_in_frame,
              (state_q == fbps_pkg::ST_CLEAR) |-> (32'(clr_q) < 32'(area_q)),
              "clear address past frame")

endmodule
